FILE: src/knn_pkg.sv
// Package for the k-nearest-neighbor vote classifier.
// Holds command and status codes, sequencer states and sizing constants; no dependencies.
`timescale 1ns / 1ps
package knn_pkg;
  localparam int MaxPoints = 4096;
  localparam int MaxK = 256;
  localparam int Features = 8;
  localparam int PctScale = 100;
  localparam int DistW = 35;

  typedef enum logic [1:0] {
    CMD_LOAD     = 2'd0,
    CMD_CLASSIFY = 2'd1,
    CMD_CLEAR    = 2'd2,
    CMD_CLEAR_ALT = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_STORED     = 2'd0,
    ST_FULL       = 2'd1,
    ST_CLASSIFIED = 2'd2,
    ST_CLEARED    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_FETCH,
    S_DIST,
    S_ACC,
    S_CHECK,
    S_SHIFT_RD,
    S_SHIFT,
    S_VOTE_RD,
    S_VOTE,
    S_DECIDE,
    S_OUT
  } state_t;

  localparam logic [1:0] RegNeighbourCount = 2'd0;
  localparam logic [1:0] RegThresholdPct = 2'd1;
endpackage

FILE: src/knn_vote_classifier.sv
// Top level of the k-nearest-neighbor vote classifier: training store, one shared
// difference-square-accumulate unit, insertion-sorted neighbor list. Uses knn_pkg.
`timescale 1ns / 1ps
// One item is in work at a time, and the block is not ready meanwhile. A load writes the
// eight features through S_LOAD and posts its result from S_OUT (the store-full case skips
// the writes and drops the point), and a clear (command 2 or 3) goes straight to S_OUT. A
// classify item walks every stored point: S_FETCH, then S_DIST streams the eight features
// through one shared 17x17 squarer and accumulator, S_ACC finishes the sum and S_CHECK
// compares it with the current k-th neighbor. A point that enters the list takes an
// S_SHIFT_RD and S_SHIFT pair for every list position it is placed at or moved past. The
// votes are then counted with an S_VOTE_RD and S_VOTE pair per neighbor used, and S_DECIDE
// and S_OUT post the result. The single-ported neighbor list and feature memory serialize
// these steps. The result sits in an output register, and the block is not ready again
// until the cycle after it is taken.
module knn_vote_classifier #(
  parameter int MAX_POINTS = knn_pkg::MaxPoints,
  parameter int MAX_K = knn_pkg::MaxK
) (
  input  logic clk,
  input  logic rst,
  input  logic valid,
  output logic ready,
  input  logic [1:0] command,
  input  logic signed [15:0] visible_energy,
  input  logic signed [15:0] hits_x,
  input  logic signed [15:0] hits_y,
  input  logic signed [15:0] hit_difference,
  input  logic signed [15:0] energy_per_hit_x,
  input  logic signed [15:0] energy_per_hit_y,
  input  logic signed [15:0] area_ratio_x,
  input  logic signed [15:0] area_ratio_y,
  input  logic label_cosmic,
  output logic out_valid,
  input  logic out_ready,
  output logic [1:0] status,
  output logic predicted_cosmic,
  output logic [8:0] cosmic_votes,
  output logic [8:0] neighbours_used,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  localparam int PW = $clog2(MAX_POINTS + 1);
  localparam int PA = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int KW = $clog2(MAX_K + 1);
  localparam int KA = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int FA = $clog2(knn_pkg::Features);
  localparam int DW = knn_pkg::DistW;
  localparam logic RegIdx0 = knn_pkg::RegNeighbourCount[0];

  knn_pkg::state_t state, state_next;

  logic [8:0] neighbour_count;
  logic [6:0] threshold_pct;
  logic [PW-1:0] stored_count;

  logic [15:0] fmem [MAX_POINTS*knn_pkg::Features];
  logic        lmem [MAX_POINTS];
  logic [DW-1:0] bdist [MAX_K];
  logic          blab [MAX_K];

  logic [15:0] q [knn_pkg::Features];
  logic [1:0] cmd;
  logic lbl;

  logic [PW-1:0] pt;
  logic [FA:0] fi;
  logic [15:0] frd;
  logic lrd, cur_lab;
  logic signed [16:0] diff;
  logic [33:0] sq;
  logic [DW-1:0] acc;
  logic [KW-1:0] used, kk, pos, vi;
  logic [DW-1:0] brd_d;
  logic brd_l;
  logic [8:0] votes;

  function automatic logic cmd_in_is(knn_pkg::cmd_t c);
    return command == c;
  endfunction

  logic in_acc, out_acc;
  assign in_acc = valid && ready;
  assign out_acc = out_valid && out_ready;
  assign ready = (state == knn_pkg::S_IDLE) && !out_valid;
  assign pready = 1'b1;

  // Configuration port.
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  always_ff @(posedge clk) begin
    if (rst) begin
      neighbour_count <= 9'd100;
      threshold_pct <= 7'd50;
    end else if (cfg_wr) begin
      if (paddr[2] == RegIdx0) neighbour_count <= pwdata[8:0];
      else threshold_pct <= pwdata[6:0];
    end
  end
  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == RegIdx0) prdata = {23'd0, neighbour_count};
    else prdata = {25'd0, threshold_pct};
  end

  // Saturated k.
  always_comb begin
    if (32'(neighbour_count) > MAX_K) kk = KW'(MAX_K);
    else kk = KW'(neighbour_count);
  end

  // Feature and label memories: one port each, registered read.
  logic f_we;
  logic [PA+FA-1:0] f_addr;
  assign f_we = (state == knn_pkg::S_LOAD) && (stored_count < PW'(MAX_POINTS));
  assign f_addr = {pt[PA-1:0], fi[FA-1:0]};
  always_ff @(posedge clk) begin
    if (f_we) fmem[f_addr] <= q[fi[FA-1:0]];
    frd <= fmem[f_addr];
  end
  always_ff @(posedge clk) begin
    if (f_we && fi == 0) lmem[pt[PA-1:0]] <= lbl;
    lrd <= lmem[pt[PA-1:0]];
  end

  // Neighbor list memory: one address, registered read.
  logic b_we;
  logic [KA-1:0] b_addr;
  logic [DW-1:0] b_wd;
  logic b_wl;
  always_comb begin
    b_we = 1'b0;
    b_addr = pos[KA-1:0] - KA'(1);
    b_wd = acc;
    b_wl = cur_lab;
    unique case (state)
      knn_pkg::S_ACC: b_addr = used[KA-1:0] - KA'(1);
      knn_pkg::S_SHIFT: begin
        b_addr = pos[KA-1:0];
        b_we = 1'b1;
        if (pos != 0 && brd_d > acc) begin
          b_wd = brd_d;
          b_wl = brd_l;
        end
      end
      knn_pkg::S_VOTE_RD: b_addr = vi[KA-1:0];
      default: ;
    endcase
  end
  always_ff @(posedge clk) begin
    if (b_we) begin
      bdist[b_addr] <= b_wd;
      blab[b_addr] <= b_wl;
    end
    brd_d <= bdist[b_addr];
    brd_l <= blab[b_addr];
  end

  // Shared squaring unit, registered.
  assign diff = 17'($signed(q[fi[FA-1:0] - FA'(1)])) - 17'($signed(frd));
  always_ff @(posedge clk) begin
    sq <= 34'($signed(diff) * $signed(diff));
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      knn_pkg::S_IDLE: if (in_acc) begin
        priority if (cmd_in_is(knn_pkg::CMD_LOAD)) state_next = knn_pkg::S_LOAD;
        else if (cmd_in_is(knn_pkg::CMD_CLASSIFY)) state_next = knn_pkg::S_FETCH;
        else state_next = knn_pkg::S_OUT;
      end
      knn_pkg::S_LOAD:
        if (stored_count >= PW'(MAX_POINTS) || fi == (FA+1)'(knn_pkg::Features - 1))
          state_next = knn_pkg::S_OUT;
      knn_pkg::S_FETCH:
        if (pt >= stored_count || kk == 0) state_next = knn_pkg::S_VOTE_RD;
        else state_next = knn_pkg::S_DIST;
      knn_pkg::S_DIST: if (fi == (FA+1)'(knn_pkg::Features)) state_next = knn_pkg::S_ACC;
      knn_pkg::S_ACC: state_next = knn_pkg::S_CHECK;
      knn_pkg::S_CHECK:
        if (used == kk && acc >= brd_d) state_next = knn_pkg::S_FETCH;
        else state_next = knn_pkg::S_SHIFT_RD;
      knn_pkg::S_SHIFT_RD: state_next = knn_pkg::S_SHIFT;
      knn_pkg::S_SHIFT:
        if (pos == 0 || !(brd_d > acc)) state_next = knn_pkg::S_FETCH;
        else state_next = knn_pkg::S_SHIFT_RD;
      knn_pkg::S_VOTE_RD:
        if (vi >= used) state_next = knn_pkg::S_DECIDE;
        else state_next = knn_pkg::S_VOTE;
      knn_pkg::S_VOTE: state_next = knn_pkg::S_VOTE_RD;
      knn_pkg::S_DECIDE: state_next = knn_pkg::S_OUT;
      knn_pkg::S_OUT: state_next = knn_pkg::S_IDLE;
      default: state_next = knn_pkg::S_IDLE;
    endcase
  end

  // Datapath and control registers.
  logic [15:0] fin [knn_pkg::Features];
  assign fin[0] = visible_energy;
  assign fin[1] = hits_x;
  assign fin[2] = hits_y;
  assign fin[3] = hit_difference;
  assign fin[4] = energy_per_hit_x;
  assign fin[5] = energy_per_hit_y;
  assign fin[6] = area_ratio_x;
  assign fin[7] = area_ratio_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= knn_pkg::S_IDLE;
      stored_count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_acc) out_valid <= 1'b0;
      unique case (state)
        knn_pkg::S_IDLE: if (in_acc) begin
          q <= fin;
          cmd <= command;
          lbl <= label_cosmic;
          fi <= '0;
          pt <= (command == knn_pkg::CMD_LOAD) ? stored_count : '0;
          used <= '0;
          votes <= '0;
          vi <= '0;
        end
        knn_pkg::S_LOAD: begin
          fi <= fi + 1'b1;
          if (stored_count < PW'(MAX_POINTS) && fi == (FA+1)'(knn_pkg::Features - 1))
            stored_count <= stored_count + 1'b1;
        end
        knn_pkg::S_FETCH: begin
          fi <= '0;
          acc <= '0;
        end
        knn_pkg::S_DIST: begin
          // fi leads the squarer output through the frd read register and the sq register.
          fi <= fi + 1'b1;
          if (fi >= 2) acc <= acc + DW'(sq);
          cur_lab <= lrd;
        end
        knn_pkg::S_ACC: begin
          acc <= acc + DW'(sq);
          pos <= used;
        end
        knn_pkg::S_CHECK: begin
          if (!(used == kk && acc >= brd_d)) begin
            if (used < kk) begin
              used <= used + 1'b1;
              pos <= used;
            end else pos <= used - 1'b1;
          end else pt <= pt + 1'b1;
        end
        knn_pkg::S_SHIFT_RD: ;
        knn_pkg::S_SHIFT: begin
          if (pos == 0 || !(brd_d > acc)) pt <= pt + 1'b1;
          else pos <= pos - 1'b1;
        end
        knn_pkg::S_VOTE_RD: ;
        knn_pkg::S_VOTE: begin
          votes <= votes + 9'(brd_l);
          vi <= vi + 1'b1;
        end
        knn_pkg::S_DECIDE: ;
        knn_pkg::S_OUT: begin
          out_valid <= 1'b1;
          if (cmd != knn_pkg::CMD_LOAD && cmd != knn_pkg::CMD_CLASSIFY)
            stored_count <= '0;
        end
        default: ;
      endcase
    end
  end

  // The CHECK read needs entry k-1; S_ACC presents used-1 on the list port.
  // Result register.
  logic [16:0] lhs, rhs;
  assign lhs = 17'(votes) * 17'(knn_pkg::PctScale);
  assign rhs = 17'(threshold_pct) * 17'(kk);
  always_ff @(posedge clk) begin
    if (state == knn_pkg::S_OUT) begin
      unique case (cmd)
        knn_pkg::CMD_LOAD: begin
          status <= (pt >= PW'(MAX_POINTS)) ? knn_pkg::ST_FULL : knn_pkg::ST_STORED;
          predicted_cosmic <= 1'b0;
          cosmic_votes <= '0;
          neighbours_used <= '0;
        end
        knn_pkg::CMD_CLASSIFY: begin
          status <= knn_pkg::ST_CLASSIFIED;
          predicted_cosmic <= lhs > rhs;
          cosmic_votes <= votes;
          neighbours_used <= 9'(used);
        end
        default: begin
          status <= knn_pkg::ST_CLEARED;
          predicted_cosmic <= 1'b0;
          cosmic_votes <= '0;
          neighbours_used <= '0;
        end
      endcase
    end
  end

  // Assertions.
  a_used_le_k: assert property (@(posedge clk) disable iff (rst)
    (state != knn_pkg::S_IDLE) |-> used <= kk)
    else $error("neighbor count exceeds k");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state != knn_pkg::S_IDLE) |-> !ready) else $error("ready while busy");
  a_out: assert property (@(posedge clk) disable iff (rst)
    (state == knn_pkg::S_OUT) |=> out_valid) else $error("result not posted");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result lost");
endmodule

FILE: tb/sv/knn_vote_classifier_tb.sv
// Self-checking testbench for knn_vote_classifier: loads, queries and clears with
// random idling on both handshakes, checked against an in-bench neighbor-vote predictor.
// Depends on knn_pkg and the knn_vote_classifier RTL.
`timescale 1ns / 1ps
module knn_vote_classifier_tb;

  typedef struct {
    logic [1:0] cmd;
    logic [7:0][15:0] feat;
    logic lab;
  } point_item_t;

  typedef struct {
    logic [1:0] status;
    logic pred;
    logic [8:0] votes;
    logic [8:0] used;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic valid = 1'b0;
  logic ready;
  logic [1:0] command = knn_pkg::CMD_LOAD;
  logic signed [15:0] visible_energy = '0, hits_x = '0, hits_y = '0, hit_difference = '0;
  logic signed [15:0] energy_per_hit_x = '0, energy_per_hit_y = '0;
  logic signed [15:0] area_ratio_x = '0, area_ratio_y = '0;
  logic label_cosmic = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic predicted_cosmic;
  logic [8:0] cosmic_votes, neighbours_used;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  knn_vote_classifier DUT (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // Predictor state: training store and the two registers.
  logic [15:0] train_feat [knn_pkg::MaxPoints][knn_pkg::Features];
  bit train_lab [knn_pkg::MaxPoints];
  int train_count = 0;
  int cfg_k = 100;
  int cfg_thr = 50;

  point_item_t pending_items[$];
  verdict_t expected_verdicts[$];
  point_item_t cur_item;
  int burst_left = 0, gap_left = 0;
  int errors = 0, checked = 0, n_loads = 0, n_queries = 0, n_clears = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int gen_count = 0;

  function automatic verdict_t classify_point(point_item_t it);
    verdict_t r;
    int k, used, pos, diff, votes;
    longint d;
    longint best_d [knn_pkg::MaxK];
    bit best_l [knn_pkg::MaxK];
    r = '{status: knn_pkg::ST_CLASSIFIED, pred: 1'b0, votes: '0, used: '0};
    case (it.cmd)
      knn_pkg::CMD_LOAD: begin
        if (train_count >= knn_pkg::MaxPoints) begin
          r.status = knn_pkg::ST_FULL;
        end else begin
          for (int f = 0; f < knn_pkg::Features; f++) train_feat[train_count][f] = it.feat[f];
          train_lab[train_count] = it.lab;
          train_count++;
          r.status = knn_pkg::ST_STORED;
        end
      end
      knn_pkg::CMD_CLASSIFY: begin
        k = (cfg_k > knn_pkg::MaxK) ? knn_pkg::MaxK : cfg_k;
        used = 0;
        votes = 0;
        if (k > 0) begin
          for (int p = 0; p < train_count; p++) begin
            d = 0;
            for (int f = 0; f < knn_pkg::Features; f++) begin
              diff = int'($signed(it.feat[f])) - int'($signed(train_feat[p][f]));
              d += longint'(diff) * longint'(diff);
            end
            // A farther or equally far point never displaces a kept one.
            if (used == k && d >= best_d[k-1]) continue;
            if (used < k) used++;
            pos = used - 1;
            while (pos > 0 && best_d[pos-1] > d) begin
              best_d[pos] = best_d[pos-1];
              best_l[pos] = best_l[pos-1];
              pos--;
            end
            best_d[pos] = d;
            best_l[pos] = train_lab[p];
          end
        end
        for (int i = 0; i < used; i++) votes += best_l[i];
        r.votes = votes[8:0];
        r.used = used[8:0];
        r.pred = (votes * knn_pkg::PctScale > cfg_thr * k);
      end
      default: begin
        train_count = 0;
        r.status = knn_pkg::ST_CLEARED;
      end
    endcase
    return r;
  endfunction

  // Sender: bursts of items separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      if (valid && ready) begin
        expected_verdicts = {expected_verdicts, classify_point(cur_item)};
      end
      if (!valid || ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          command <= cur_item.cmd;
          visible_energy <= cur_item.feat[0];
          hits_x <= cur_item.feat[1];
          hits_y <= cur_item.feat[2];
          hit_difference <= cur_item.feat[3];
          energy_per_hit_x <= cur_item.feat[4];
          energy_per_hit_y <= cur_item.feat[5];
          area_ratio_x <= cur_item.feat[6];
          area_ratio_y <= cur_item.feat[7];
          label_cosmic <= cur_item.lab;
          valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          valid <= 1'b0;
        end
      end
    end
  end

  // Receiver and checker.
  always @(posedge clk) begin
    verdict_t exp_v;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          $display("%t: result with nothing expected: status %0d", $time, status);
          errors++;
        end else begin
          exp_v = expected_verdicts.pop_front();
          checked++;
          case (exp_v.status)
            knn_pkg::ST_CLASSIFIED: n_queries++;
            knn_pkg::ST_CLEARED: n_clears++;
            default: n_loads++;
          endcase
          if (status !== exp_v.status) begin
            $display("%t: status expected %0d got %0d", $time, exp_v.status, status);
            errors++;
          end
          if (predicted_cosmic !== exp_v.pred) begin
            $display("%t: predicted_cosmic expected %0d got %0d", $time, exp_v.pred,
                     predicted_cosmic);
            errors++;
          end
          if (cosmic_votes !== exp_v.votes) begin
            $display("%t: cosmic_votes expected %0d got %0d", $time, exp_v.votes,
                     cosmic_votes);
            errors++;
          end
          if (neighbours_used !== exp_v.used) begin
            $display("%t: neighbours_used expected %0d got %0d", $time, exp_v.used,
                     neighbours_used);
            errors++;
          end
        end
      end
      // One long hold-off while the sender keeps offering, so the input backs up.
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!hold_done && checked == 30) begin
        hold_done <= 1'b1;
        hold_left <= 400;
        out_ready <= 1'b0;
      end else if ((checked / 16) % 3 == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 2) != 0);
      end
    end
  end

  task automatic add_item(input logic [1:0] cmd, input logic [7:0][15:0] feat, input logic lab);
    point_item_t it;
    it.cmd = cmd;
    it.feat = feat;
    it.lab = lab;
    pending_items = {pending_items, it};
  endtask

  function automatic logic [7:0][15:0] fill_feat(input logic [15:0] v);
    logic [7:0][15:0] x;
    for (int f = 0; f < knn_pkg::Features; f++) x[f] = v;
    return x;
  endfunction

  // Mostly clustered values so that ties and mixed votes occur; some full-range.
  function automatic logic [7:0][15:0] rand_feat();
    logic [7:0][15:0] x;
    int mode;
    mode = $urandom_range(0, 3);
    for (int f = 0; f < knn_pkg::Features; f++) begin
      if (mode == 0) x[f] = 16'($urandom);
      else x[f] = 16'($signed($urandom_range(0, 8)) - 4);
    end
    return x;
  endfunction

  task automatic wait_idle();
    while (pending_items.size() > 0 || valid || expected_verdicts.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input int value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 1'b0} << 1;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == knn_pkg::RegNeighbourCount) cfg_k = value & 32'h1FF;
    else cfg_thr = value & 32'h7F;
    // Read the register back on the same address.
    @(posedge clk);
    if (prdata !== 32'((idx == knn_pkg::RegNeighbourCount) ? cfg_k : cfg_thr)) begin
      $display("%t: register %0d read expected %0d got %0d", $time, idx,
               (idx == knn_pkg::RegNeighbourCount) ? cfg_k : cfg_thr, prdata);
      errors++;
    end
  endtask

  task automatic random_phase(input int n);
    int c;
    for (int i = 0; i < n; i++) begin
      c = $urandom_range(0, 9);
      if (gen_count > 40 && c < 3) c = 9;
      if (c < 5) begin
        add_item(knn_pkg::CMD_LOAD, rand_feat(), 1'($urandom_range(0, 1)));
        gen_count++;
      end else if (c < 9) begin
        add_item(knn_pkg::CMD_CLASSIFY, rand_feat(), 1'($urandom_range(0, 1)));
      end else begin
        add_item($urandom_range(0, 1) ? knn_pkg::CMD_CLEAR : knn_pkg::CMD_CLEAR_ALT,
                 rand_feat(), 1'($urandom_range(0, 1)));
        gen_count = 0;
      end
    end
  endtask

  initial begin
    int ks[7] = '{1, 3, 0, 511, 256, 7, 5};
    int ts[7] = '{0, 50, 50, 127, 100, 33, 100};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    reg_write(knn_pkg::RegNeighbourCount, 3);
    reg_write(knn_pkg::RegThresholdPct, 50);

    // Directed: empty store, extremes, duplicate points, both clear codes.
    add_item(knn_pkg::CMD_CLASSIFY, fill_feat(16'h0000), 1'b1);
    add_item(knn_pkg::CMD_LOAD, fill_feat(16'h7FFF), 1'b1);
    add_item(knn_pkg::CMD_LOAD, fill_feat(16'h8000), 1'b0);
    add_item(knn_pkg::CMD_CLASSIFY, fill_feat(16'h8000), 1'b0);
    add_item(knn_pkg::CMD_CLASSIFY, fill_feat(16'h7FFF), 1'b0);
    add_item(knn_pkg::CMD_LOAD, fill_feat(16'h0001), 1'b0);
    add_item(knn_pkg::CMD_LOAD, fill_feat(16'h0001), 1'b1);
    add_item(knn_pkg::CMD_LOAD, fill_feat(16'hFFFF), 1'b1);
    add_item(knn_pkg::CMD_CLASSIFY, fill_feat(16'h0000), 1'b1);
    add_item(knn_pkg::CMD_CLASSIFY, fill_feat(16'h0001), 1'b0);
    add_item(knn_pkg::CMD_CLEAR_ALT, fill_feat(16'h5555), 1'b1);
    add_item(knn_pkg::CMD_CLASSIFY, fill_feat(16'hAAAA), 1'b0);
    add_item(knn_pkg::CMD_LOAD, fill_feat(16'hAAAA), 1'b1);
    add_item(knn_pkg::CMD_CLASSIFY, fill_feat(16'h5555), 1'b1);
    add_item(knn_pkg::CMD_CLEAR, fill_feat(16'h0000), 1'b0);
    gen_count = 0;
    wait_idle();

    for (int ph = 0; ph < 7; ph++) begin
      reg_write(knn_pkg::RegNeighbourCount, ks[ph]);
      reg_write(knn_pkg::RegThresholdPct, ts[ph]);
      random_phase(18);
      wait_idle();
    end

    // A small store queried with one neighbor and a zero threshold, then cleared.
    reg_write(knn_pkg::RegNeighbourCount, 1);
    reg_write(knn_pkg::RegThresholdPct, 0);
    add_item(knn_pkg::CMD_CLEAR, fill_feat(16'h0000), 1'b0);
    for (int i = 0; i < 4; i++)
      add_item(knn_pkg::CMD_LOAD, rand_feat(), 1'($urandom_range(0, 1)));
    add_item(knn_pkg::CMD_LOAD, fill_feat(16'h1234), 1'b1);
    add_item(knn_pkg::CMD_CLASSIFY, fill_feat(16'h1234), 1'b0);
    add_item(knn_pkg::CMD_CLEAR_ALT, fill_feat(16'h0000), 1'b0);
    wait_idle();
    repeat (50) @(posedge clk);

    $display("Checked %0d results: %0d loads, %0d queries, %0d clears,",
             checked, n_loads, n_queries, n_clears);
    $display("across nine k/threshold settings with stalls and bursts on both handshakes.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #15ms;
    $display("Timeout with %0d results still expected", expected_verdicts.size());
    $display("Simulation FAILED");
    $finish;
  end
endmodule
